@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ rtl/fdr_pkg.sv @@
package fdr_pkg;

   typedef struct packed {
      logic signed [15:0] cos_incident;
      logic [15:0]        index_incident;
      logic [15:0]        index_transmit;
   } fdr_req_type;

   typedef struct packed {
      logic [15:0] reflectance;
      logic        total_internal;
   } fdr_rsp_type;

   localparam logic [15:0] ONE_Q15 = 16'h8000;

   // squared transmitted cosine (Q0.30, at most 2^30) and its root
   localparam int SQ_IN_W  = 31;
   localparam int SQ_OUT_W = 16;
   localparam int SQ_STEPS = 16;

   // c2 = (rhs - lhs) / nt^2
   localparam int C2_NUM_W = 62;
   localparam int C2_DEN_W = 32;
   localparam int C2_QUO_W = 31;

   // amplitude ratio |x - y| * 2^16 / (x + y)
   localparam int AR_NUM_W = 48;
   localparam int AR_DEN_W = 32;
   localparam int AR_QUO_W = 17;

   // side data riding along the first divider and the root: tir, m, ni, nt
   localparam int SIDE_W = 49;

endpackage

@@ rtl/fdr_divider.sv @@
module fdr_divider #(
   parameter int NW = 62,
   parameter int DW = 32,
   parameter int QW = 31,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QW-1:0] out_quo,
   output logic [SW-1:0] out_side
);
   // restoring divider, one quotient bit per stage, msb first;
   // caller guarantees num < den * 2^QW
   localparam int RW = DW + QW;

   logic          valid_ff [QW];
   logic [RW-1:0] rem_ff   [QW];
   logic [DW-1:0] den_ff   [QW];
   logic [QW-1:0] quo_ff   [QW];
   logic [SW-1:0] side_ff  [QW];

   logic          st_valid [QW];
   logic [RW-1:0] st_rem   [QW];
   logic [DW-1:0] st_den   [QW];
   logic [QW-1:0] st_quo   [QW];
   logic [SW-1:0] st_side  [QW];

   logic [RW-1:0] trial    [QW];
   logic          take     [QW];
   logic [RW-1:0] rem_in   [QW];
   logic [QW-1:0] quo_in   [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      localparam int Shift = QW - 1 - k;

      if (k == 0) begin : g_first
         assign st_valid[k] = in_valid;
         assign st_rem[k]   = RW'(in_num);
         assign st_den[k]   = in_den;
         assign st_quo[k]   = '0;
         assign st_side[k]  = in_side;
      end else begin : g_next
         assign st_valid[k] = valid_ff[k-1];
         assign st_rem[k]   = rem_ff[k-1];
         assign st_den[k]   = den_ff[k-1];
         assign st_quo[k]   = quo_ff[k-1];
         assign st_side[k]  = side_ff[k-1];
      end

      assign trial[k]  = RW'(st_den[k]) << Shift;
      assign take[k]   = st_rem[k] >= trial[k];
      assign rem_in[k] = take[k] ? (st_rem[k] - trial[k]) : st_rem[k];
      assign quo_in[k] = st_quo[k] | (QW'(take[k]) << Shift);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= st_valid[k];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in[k];
         den_ff[k]  <= st_den[k];
         quo_ff[k]  <= quo_in[k];
         side_ff[k] <= st_side[k];
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_quo   = quo_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

@@ rtl/fdr_isqrt.sv @@
module fdr_isqrt #(
   parameter int SW = 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [fdr_pkg::SQ_IN_W-1:0]    in_val,
   input  logic [SW-1:0]                  in_side,
   output logic                           out_valid,
   output logic [fdr_pkg::SQ_OUT_W-1:0]   out_root,
   output logic [SW-1:0]                  out_side
);
   import fdr_pkg::*;

   // digit-by-digit root, one result bit per stage
   localparam int VW = SQ_IN_W + 1;

   logic          valid_ff [SQ_STEPS];
   logic [VW-1:0] val_ff   [SQ_STEPS];
   logic [VW-1:0] res_ff   [SQ_STEPS];
   logic [SW-1:0] side_ff  [SQ_STEPS];

   logic          st_valid [SQ_STEPS];
   logic [VW-1:0] st_val   [SQ_STEPS];
   logic [VW-1:0] st_res   [SQ_STEPS];
   logic [SW-1:0] st_side  [SQ_STEPS];

   logic [VW-1:0] trial    [SQ_STEPS];
   logic          take     [SQ_STEPS];
   logic [VW-1:0] val_in   [SQ_STEPS];
   logic [VW-1:0] res_in   [SQ_STEPS];

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stage
      localparam int BitPos = 2 * (SQ_STEPS - 1 - k);
      localparam logic [VW-1:0] Bit = VW'(1) << BitPos;

      if (k == 0) begin : g_first
         assign st_valid[k] = in_valid;
         assign st_val[k]   = VW'(in_val);
         assign st_res[k]   = '0;
         assign st_side[k]  = in_side;
      end else begin : g_next
         assign st_valid[k] = valid_ff[k-1];
         assign st_val[k]   = val_ff[k-1];
         assign st_res[k]   = res_ff[k-1];
         assign st_side[k]  = side_ff[k-1];
      end

      assign trial[k]  = st_res[k] + Bit;
      assign take[k]   = st_val[k] >= trial[k];
      assign val_in[k] = take[k] ? (st_val[k] - trial[k]) : st_val[k];
      assign res_in[k] = take[k] ? ((st_res[k] >> 1) + Bit) : (st_res[k] >> 1);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= st_valid[k];
         end
      end

      always_ff @(posedge clock) begin
         val_ff[k]  <= val_in[k];
         res_ff[k]  <= res_in[k];
         side_ff[k] <= st_side[k];
      end
   end

   assign out_valid = valid_ff[SQ_STEPS-1];
   assign out_root  = res_ff[SQ_STEPS-1][SQ_OUT_W-1:0];
   assign out_side  = side_ff[SQ_STEPS-1];

endmodule

@@ rtl/fresnel_dielectric_reflectance.sv @@
// Throughput: one transaction per cycle; busy is always low. The pipeline is
// built from the s1-s8 registers, the 31-stage c2 divider, the 16-stage root
// and two 17-stage ratio dividers that run in parallel.
// The receiver cannot stall: each result is shown for one cycle only.
// Reset (synchronous, active high) clears every stage valid bit; transactions
// in flight are dropped. Payload registers are not reset.
`include "assert_macros.svh"

module fresnel_dielectric_reflectance (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  fdr_pkg::fdr_req_type req_data,
   output logic                 rsp_strobe,
   output fdr_pkg::fdr_rsp_type rsp_data
);
   import fdr_pkg::*;

   // Pipeline map:
   //   s1  fold sign: |cos|, swap indices when leaving the medium
   //   s2  squares m^2, ni^2, nt^2
   //   s3  lhs = ni^2 * (2^30 - m^2)
   //   s4  TIR compare against nt^2 * 2^30, numerator for c2
   //   div c2 = num / nt^2              (31 stages)
   //   sqr ct = sqrt(c2)                (16 stages)
   //   s5  the four Q5.27 products
   //   s6  sums and differences of each pair
   //   div two ratios in parallel       (17 stages)
   //   s7  squares of the ratios
   //   s8  mean, round, saturate, TIR override -> output register

   assign busy = 1'b0;

   // ---------------- s1: sign fold and swap ----------------
   logic        accept;
   logic        neg;
   logic        swap;
   logic [16:0] m_wide;
   logic        s1_valid_ff;
   logic [15:0] s1_m_ff, s1_m_in;
   logic [15:0] s1_ni_ff, s1_ni_in;
   logic [15:0] s1_nt_ff, s1_nt_in;

   assign accept   = start && !busy;
   assign neg      = req_data.cos_incident[15];
   assign swap     = neg || (req_data.cos_incident == 16'sd0);
   assign m_wide   = neg ? (17'h10000 - {1'b0, req_data.cos_incident})
                         : {1'b0, req_data.cos_incident};
   assign s1_m_in  = m_wide[15:0];   // at most 32768
   assign s1_ni_in = swap ? req_data.index_transmit : req_data.index_incident;
   assign s1_nt_in = swap ? req_data.index_incident : req_data.index_transmit;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_m_ff  <= s1_m_in;
      s1_ni_ff <= s1_ni_in;
      s1_nt_ff <= s1_nt_in;
   end

   // ---------------- s2: squares ----------------
   logic        s2_valid_ff;
   logic [31:0] s2_mm_ff, s2_ni2_ff, s2_nt2_ff;
   logic [15:0] s2_m_ff, s2_ni_ff, s2_nt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_mm_ff  <= 32'(s1_m_ff) * 32'(s1_m_ff);
      s2_ni2_ff <= 32'(s1_ni_ff) * 32'(s1_ni_ff);
      s2_nt2_ff <= 32'(s1_nt_ff) * 32'(s1_nt_ff);
      s2_m_ff   <= s1_m_ff;
      s2_ni_ff  <= s1_ni_ff;
      s2_nt_ff  <= s1_nt_ff;
   end

   // ---------------- s3: ni^2 * sin^2 ----------------
   logic [30:0] sin2;
   logic        s3_valid_ff;
   logic [62:0] s3_lhs_ff;
   logic [31:0] s3_nt2_ff;
   logic [15:0] s3_m_ff, s3_ni_ff, s3_nt_ff;

   // m^2 <= 2^30, so this never wraps
   assign sin2 = 31'h4000_0000 - s2_mm_ff[30:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_lhs_ff <= 63'(s2_ni2_ff) * 63'(sin2);
      s3_nt2_ff <= s2_nt2_ff;
      s3_m_ff   <= s2_m_ff;
      s3_ni_ff  <= s2_ni_ff;
      s3_nt_ff  <= s2_nt_ff;
   end

   // ---------------- s4: TIR test ----------------
   logic [62:0] rhs;
   logic        tir_in;
   logic        s4_valid_ff;
   logic        s4_tir_ff;
   logic [C2_NUM_W-1:0] s4_num_ff, s4_num_in;
   logic [31:0] s4_nt2_ff;
   logic [15:0] s4_m_ff, s4_ni_ff, s4_nt_ff;

   assign rhs       = {1'b0, s3_nt2_ff, 30'd0};
   assign tir_in    = s3_lhs_ff >= rhs;     // nt = 0 always lands here
   assign s4_num_in = tir_in ? '0 : C2_NUM_W'(rhs - s3_lhs_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_tir_ff <= tir_in;
      s4_num_ff <= s4_num_in;
      s4_nt2_ff <= s3_nt2_ff;
      s4_m_ff   <= s3_m_ff;
      s4_ni_ff  <= s3_ni_ff;
      s4_nt_ff  <= s3_nt_ff;
   end

   // ---------------- c2 divider and root ----------------
   logic                div_c2_valid;
   logic [C2_QUO_W-1:0] div_c2_quo;
   logic [SIDE_W-1:0]   div_c2_side;

   fdr_divider #(
      .NW (C2_NUM_W),
      .DW (C2_DEN_W),
      .QW (C2_QUO_W),
      .SW (SIDE_W)
   ) u_div_c2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s4_valid_ff),
      .in_num    (s4_num_ff),
      .in_den    (s4_nt2_ff),
      .in_side   ({s4_tir_ff, s4_m_ff, s4_ni_ff, s4_nt_ff}),
      .out_valid (div_c2_valid),
      .out_quo   (div_c2_quo),
      .out_side  (div_c2_side)
   );

   logic                sq_valid;
   logic [SQ_OUT_W-1:0] sq_root;
   logic [SIDE_W-1:0]   sq_side;

   fdr_isqrt #(
      .SW (SIDE_W)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_c2_valid),
      .in_val    (div_c2_quo),
      .in_side   (div_c2_side),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // ---------------- s5: amplitude products ----------------
   logic        sq_tir;
   logic [15:0] sq_m, sq_ni, sq_nt;
   logic        s5_valid_ff;
   logic        s5_tir_ff;
   logic [31:0] s5_xpa_ff, s5_ypa_ff, s5_xpe_ff, s5_ype_ff;

   assign {sq_tir, sq_m, sq_ni, sq_nt} = sq_side;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      s5_tir_ff <= sq_tir;
      s5_xpa_ff <= 32'(sq_nt) * 32'(sq_m);
      s5_ypa_ff <= 32'(sq_ni) * 32'(sq_root);
      s5_xpe_ff <= 32'(sq_ni) * 32'(sq_m);
      s5_ype_ff <= 32'(sq_nt) * 32'(sq_root);
   end

   // ---------------- s6: ratio operands ----------------
   logic        s6_valid_ff;
   logic        s6_tir_ff;
   logic        s6_zpa_ff, s6_zpe_ff;
   logic [31:0] s6_dpa_ff, s6_dpe_ff;
   logic [31:0] s6_fpa_ff, s6_fpe_ff;   // |x - y|

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s6_tir_ff <= s5_tir_ff;
      s6_zpa_ff <= (s5_xpa_ff == 32'd0) && (s5_ypa_ff == 32'd0);
      s6_zpe_ff <= (s5_xpe_ff == 32'd0) && (s5_ype_ff == 32'd0);
      s6_dpa_ff <= s5_xpa_ff + s5_ypa_ff;   // both < 2^31, no carry out
      s6_dpe_ff <= s5_xpe_ff + s5_ype_ff;
      s6_fpa_ff <= (s5_xpa_ff >= s5_ypa_ff) ? (s5_xpa_ff - s5_ypa_ff)
                                             : (s5_ypa_ff - s5_xpa_ff);
      s6_fpe_ff <= (s5_xpe_ff >= s5_ype_ff) ? (s5_xpe_ff - s5_ype_ff)
                                             : (s5_ype_ff - s5_xpe_ff);
   end

   // ---------------- ratio dividers ----------------
   logic                pa_valid, pe_valid;
   logic [AR_QUO_W-1:0] pa_quo, pe_quo;
   logic [1:0]          pa_side;
   logic                pe_side;

   fdr_divider #(
      .NW (AR_NUM_W),
      .DW (AR_DEN_W),
      .QW (AR_QUO_W),
      .SW (2)
   ) u_div_pa (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s6_valid_ff),
      .in_num    ({s6_fpa_ff, 16'd0}),
      .in_den    (s6_dpa_ff),
      .in_side   ({s6_tir_ff, s6_zpa_ff}),
      .out_valid (pa_valid),
      .out_quo   (pa_quo),
      .out_side  (pa_side)
   );

   fdr_divider #(
      .NW (AR_NUM_W),
      .DW (AR_DEN_W),
      .QW (AR_QUO_W),
      .SW (1)
   ) u_div_pe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s6_valid_ff),
      .in_num    ({s6_fpe_ff, 16'd0}),
      .in_den    (s6_dpe_ff),
      .in_side   (s6_zpe_ff),
      .out_valid (pe_valid),
      .out_quo   (pe_quo),
      .out_side  (pe_side)
   );

   // ---------------- s7: squared ratios ----------------
   logic [AR_QUO_W-1:0] rpa, rpe;
   logic                s7_valid_ff;
   logic                s7_tir_ff;
   logic [33:0]         s7_sqpa_ff, s7_sqpe_ff;

   // zero denominator counts as a ratio of one
   assign rpa = pa_side[0] ? 17'h10000 : pa_quo;
   assign rpe = pe_side    ? 17'h10000 : pe_quo;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else begin
         s7_valid_ff <= pa_valid;
      end
   end

   always_ff @(posedge clock) begin
      s7_tir_ff  <= pa_side[1];
      s7_sqpa_ff <= 34'(rpa) * 34'(rpa);
      s7_sqpe_ff <= 34'(rpe) * 34'(rpe);
   end

   // ---------------- s8: mean, round, saturate, TIR override ----------------
   logic [34:0] rounded;
   logic [16:0] refl_wide;
   logic [15:0] refl_sat;
   logic        rsp_strobe_ff;
   fdr_rsp_type rsp_data_ff, rsp_data_in;

   assign rounded   = 35'(s7_sqpa_ff) + 35'(s7_sqpe_ff) + 35'h2_0000;
   assign refl_wide = rounded[34:18];
   assign refl_sat  = (refl_wide > 17'(ONE_Q15)) ? ONE_Q15 : refl_wide[15:0];

   always_comb begin
      rsp_data_in = '0;
      if (s7_tir_ff) begin
         rsp_data_in.reflectance    = ONE_Q15;
         rsp_data_in.total_internal = 1'b1;
      end else begin
         rsp_data_in.reflectance    = refl_sat;
         rsp_data_in.total_internal = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= s7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // ---------------- checks ----------------
   `ASSERT_SAME(a_tir_full, clock, reset, rsp_strobe && rsp_data.total_internal, rsp_data.reflectance == ONE_Q15)
   `ASSERT_SAME(a_refl_max, clock, reset, rsp_strobe, rsp_data.reflectance <= ONE_Q15)
   `ASSERT_SAME(a_ratio_lockstep, clock, reset, 1'b1, pa_valid == pe_valid)
   `ASSERT_NEXT(a_strobe_follows, clock, reset, s7_valid_ff, rsp_strobe)

endmodule
